/* hdl/sobel_gradient_magnitude_unit_assert.svh */
// assertion macros for the sobel gradient magnitude unit checker
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_ASSERT_SVH

// property checked only while out of reset
`define SGM_ASSERT_RUN(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define SGM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/sgm_pkg.sv */
// shared constants and types for the sobel gradient magnitude unit
package sgm_pkg;

  localparam int PIX_W      = 8;
  localparam int MAG_W      = 8;
  localparam int COORD_W    = 10;
  localparam int REG_W      = 11;
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 3;
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;
  localparam int MIN_DIM    = 3;

  // gradient and square root datapath
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 21;
  localparam int ROOT_W     = 11;
  localparam int MAG_MAX    = 255;

  // result tdata layout, lowest bit first
  localparam int MAG_LSB    = 0;
  localparam int ROW_LSB    = MAG_LSB + MAG_W;
  localparam int ROW_MSB    = ROW_LSB + COORD_W - 1;
  localparam int COL_LSB    = ROW_MSB + 1;
  localparam int COL_MSB    = COL_LSB + COORD_W - 1;
  localparam int OUT_DW     = 32;
  localparam int IN_DW      = 8;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e_t;

endpackage

/* hdl/sgm_ram.sv */
// generic single-port-write, registered-read ram
module sgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sobel_gradient_magnitude_unit.sv */
// sobel 3x3 gradient magnitude over an 8-bit raster pixel stream
//
// input stream: one 8-bit pixel per transfer on in_tdata, raster order,
// frame geometry set by the image_width / image_height registers (apb port,
// width at byte address 0, height at 4, clamped to 3..MAX_WIDTH and 3..1024).
// result stream: for each interior pixel, one transfer on out_tdata carrying
// magnitude, row and column, with out_tlast on the last interior pixel of the
// frame. border pixels give no transfer.
// both line stores share one ram (depth MAX_WIDTH, 16 bits wide) that is read
// at the accepted column and written back in the next cycle.
// a border pixel passes through a ram read, then write-back and window shift.
// an interior pixel adds a gradient step, a squaring step, a bit-per-cycle square
// root and a rounding step that loads the output register. the square root
// iteration sets the throughput.
// the output register frees the input side: a new pixel is taken while a
// result waits; only a second finished result waits for out_tready.
// reset clears counters, window, output valid and reloads 640 x 480; the
// line store contents stay undefined until written.
module sobel_gradient_magnitude_unit import sgm_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // apb configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  // pixel input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [7:0] pixel_value
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [7:0] magnitude, [17:8] out_row,
                                        // [27:18] out_col, [31:28] zero
  output logic              out_tlast   // last_of_frame
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = ($clog2(MAX_WIDTH + 1) > REG_W) ? $clog2(MAX_WIDTH + 1) : REG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQ,
    S_ROOT,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [REG_W-1:0] img_width_r;
  logic [REG_W-1:0] img_height_r;
  logic             cfg_wr;

  // raster position of the next pixel
  logic [CW-1:0]    col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;

  // the accepted pixel and its position
  logic [PIX_W-1:0] px_r;
  logic [CW-1:0]    col_hold_r;
  logic [ROW_W-1:0] row_hold_r;
  logic             emit_r;
  logic             last_r;

  // window, row-major, right column newest
  logic [PIX_W-1:0] taps_r [9];

  // gradient and root datapath
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic [SQ_W-1:0]          rem_r, q_r, bit_r;

  // output register
  logic              out_valid_r;
  logic [MAG_W-1:0]  mag_r;
  logic [COORD_W-1:0] orow_r, ocol_r;
  logic              olast_r;

  // apb: register index is paddr bit 2, pready tied high
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (cfg_reg_e_t'(cfg_paddr[2]))
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DW'(img_width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DW'(img_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // effective geometry
  logic [WB-1:0]    width_ext, w_eff;
  logic [REG_W-1:0] h_eff;
  logic [WB-1:0]    col_p1;
  logic [REG_W-1:0] row_p1;
  logic             col_end, row_end;

  always_comb begin
    width_ext = WB'(img_width_r);
    if (width_ext < WB'(MIN_DIM)) begin
      w_eff = WB'(MIN_DIM);
    end else if (width_ext > WB'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (img_height_r < REG_W'(MIN_DIM)) begin
      h_eff = REG_W'(MIN_DIM);
    end else if (img_height_r > REG_W'(MAX_HEIGHT)) begin
      h_eff = REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_height_r;
    end
    col_p1  = WB'(col_cnt_r) + WB'(1);
    row_p1  = REG_W'(row_cnt_r) + REG_W'(1);
    col_end = (col_p1 >= w_eff);
    row_end = (row_p1 >= h_eff);
  end

  // line store ram: [7:0] previous line, [15:8] the line before
  logic [2*PIX_W-1:0] ls_rdata;
  logic               ls_we;

  assign ls_we = (state_r == S_READ);

  sgm_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (col_hold_r),
    .wdata ({ls_rdata[PIX_W-1:0], px_r}),
    .raddr (col_cnt_r),
    .rdata (ls_rdata)
  );

  // sobel sums, positive and negative halves
  logic [GRAD_W-2:0]        gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRAD_W-1:0] gx_c, gy_c;

  always_comb begin
    gx_pos = (GRAD_W-1)'(taps_r[2]) + (GRAD_W-1)'({taps_r[5], 1'b0})
           + (GRAD_W-1)'(taps_r[8]);
    gx_neg = (GRAD_W-1)'(taps_r[0]) + (GRAD_W-1)'({taps_r[3], 1'b0})
           + (GRAD_W-1)'(taps_r[6]);
    gy_pos = (GRAD_W-1)'(taps_r[6]) + (GRAD_W-1)'({taps_r[7], 1'b0})
           + (GRAD_W-1)'(taps_r[8]);
    gy_neg = (GRAD_W-1)'(taps_r[0]) + (GRAD_W-1)'({taps_r[1], 1'b0})
           + (GRAD_W-1)'(taps_r[2]);
    gx_c   = signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
    gy_c   = signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});
  end

  // squares
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SQ_W-1:0]            sum_sq;

  assign gx_sq  = gx_r * gx_r;
  assign gy_sq  = gy_r * gy_r;
  assign sum_sq = SQ_W'(gx_sq) + SQ_W'(gy_sq);

  // one square root step
  logic [SQ_W:0]   trial;
  logic            take;
  logic [SQ_W-1:0] rem_step, q_step;

  always_comb begin
    trial = {1'b0, q_r} + {1'b0, bit_r};
    take  = ({1'b0, rem_r} >= trial);
    if (take) begin
      rem_step = rem_r - SQ_W'(trial);
      q_step   = (q_r >> 1) + bit_r;
    end else begin
      rem_step = rem_r;
      q_step   = q_r >> 1;
    end
  end

  // rounding: s > q*q + q is the same as remainder > q
  logic [ROOT_W-1:0] root_rnd;
  logic [MAG_W-1:0]  mag_sat;
  logic              out_free;

  always_comb begin
    root_rnd = ROOT_W'(q_r) + ROOT_W'(rem_r > q_r);
    mag_sat  = (root_rnd > ROOT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : MAG_W'(root_rnd);
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  logic [CW-1:0]    col_m1;
  logic [ROW_W-1:0] row_m1;

  assign col_m1 = col_hold_r - CW'(1);
  assign row_m1 = row_hold_r - ROW_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      img_width_r  <= REG_W'(640);
      img_height_r <= REG_W'(480);
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        taps_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (cfg_reg_e_t'(cfg_paddr[2]))
          REG_IMAGE_WIDTH:  img_width_r  <= cfg_pwdata[REG_W-1:0];
          REG_IMAGE_HEIGHT: img_height_r <= cfg_pwdata[REG_W-1:0];
          default: ;
        endcase
      end

      // a result taken with no new one finishing empties the output register
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            px_r       <= in_tdata[PIX_W-1:0];
            col_hold_r <= col_cnt_r;
            row_hold_r <= row_cnt_r;
            emit_r     <= (row_cnt_r >= ROW_W'(2)) && (WB'(col_cnt_r) >= WB'(2));
            last_r     <= col_end && row_end;
            if (col_end) begin
              col_cnt_r <= '0;
              row_cnt_r <= row_end ? '0 : ROW_W'(row_p1);
            end else begin
              col_cnt_r <= CW'(col_p1);
            end
            state_r <= S_READ;
          end
        end
        S_READ: begin
          // ram data for the held column is valid now; shift the window
          taps_r[0] <= taps_r[1];
          taps_r[1] <= taps_r[2];
          taps_r[2] <= ls_rdata[2*PIX_W-1:PIX_W];
          taps_r[3] <= taps_r[4];
          taps_r[4] <= taps_r[5];
          taps_r[5] <= ls_rdata[PIX_W-1:0];
          taps_r[6] <= taps_r[7];
          taps_r[7] <= taps_r[8];
          taps_r[8] <= px_r;
          state_r   <= emit_r ? S_GRAD : S_IDLE;
        end
        S_GRAD: begin
          gx_r    <= gx_c;
          gy_r    <= gy_c;
          state_r <= S_SQ;
        end
        S_SQ: begin
          rem_r   <= sum_sq;
          q_r     <= '0;
          bit_r   <= SQ_W'(1) << (SQ_W - 1);
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          rem_r <= rem_step;
          q_r   <= q_step;
          bit_r <= bit_r >> 2;
          if (bit_r == SQ_W'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            mag_r       <= mag_sat;
            orow_r      <= COORD_W'(row_m1);
            ocol_r      <= COORD_W'(col_m1);
            olast_r     <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = OUT_DW'({ocol_r, orow_r, mag_r});

endmodule

/* hdl/sgm_checker.sv */
// port-level checker for the sobel gradient magnitude unit, with its bind
`include "sobel_gradient_magnitude_unit_assert.svh"

module sgm_checker import sgm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tlast
);

  // a stalled result holds
  `SGM_ASSERT_RUN(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // reset empties the output register
  `SGM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // one pixel at a time: busy right after a transfer
  `SGM_ASSERT_RUN(a_busy_after_in, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "pixel taken while busy")

  // results only for interior rows
  `SGM_ASSERT_RUN(a_row_interior, clk, rst_n, out_tvalid |-> out_tdata[ROW_MSB:ROW_LSB] != 0, "border row emitted")

endmodule

bind sobel_gradient_magnitude_unit sgm_checker u_sgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
